[design/jdz_pkg.sv]
// ----------------------------------------------------------------------------
// jdz_pkg: shared definitions for the stick dead-zone rescaler
// Register indexes, value kinds, fixed-point constants and reset values.
// ----------------------------------------------------------------------------
package jdz_pkg;

  // Fixed-point format of thresholds and results (unsigned Q1.14).
  localparam int          FRAC_BITS = 14;
  localparam int          THR_W     = 15;
  localparam int          QUO_W     = 15;
  localparam logic [14:0] ONE_Q     = 15'd16384;

  // Default sample width.
  localparam int DEFAULT_SAMPLE_WIDTH = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = THR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOVE_THR  = 3'd0,
    REG_LOOK_THR  = 3'd1,
    REG_STICK_SEL = 3'd2,
    REG_UPPER_THR = 3'd3,
    REG_DZ_MODE   = 3'd4
  } cfg_idx_e;

  // Reset values of the registers.
  localparam logic [14:0] RST_MOVE_THR  = 15'd3277;
  localparam logic [14:0] RST_LOOK_THR  = 15'd3277;
  localparam logic        RST_STICK_SEL = 1'b0;
  localparam logic [14:0] RST_UPPER_THR = 15'd16384;
  localparam logic        RST_DZ_MODE   = 1'b0;

  // Dead-zone mode codes.
  localparam logic MODE_AXIAL  = 1'b0;
  localparam logic MODE_RADIAL = 1'b1;

  // Value kind of a sample.
  typedef enum logic [1:0] {
    KIND_BOOL = 2'd0,
    KIND_1D   = 2'd1,
    KIND_2D   = 2'd2,
    KIND_3D   = 2'd3
  } kind_e;

endpackage

[design/joystick_dead_zone_rescale.sv]
// ----------------------------------------------------------------------------
// joystick_dead_zone_rescale: stick dead-zone removal with rescaling
// Axial or radial dead zone on one stick sample, Q2.14 in and out.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one word per cycle unless the output stalls: a
//   value kind and signed X, Y and Z samples. The output channel returns one
//   rescaled word per input word, in order. Both use valid/ready handshakes.
//   Registers are written through the configuration channel, which is always
//   ready; write them only while no word is in flight.
// Timing:
//   Throughput is one word per cycle unless the output stalls. The pipeline
//   holds the bit-per-stage square root (SAMPLE_WIDTH stages), then the scale
//   divider and the lane dividers, each bit-per-stage with 15 stages.
// Reset:
//   Reset empties the pipeline and loads the register defaults.
// Stall:
//   When the receiver holds ready low with a word waiting, the whole pipeline
//   freezes and input ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module joystick_dead_zone_rescale #(
  parameter int SAMPLE_WIDTH = jdz_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [jdz_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [jdz_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         kind_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_z_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]     out_x_o,
  output logic signed [SAMPLE_WIDTH-1:0]     out_y_o,
  output logic signed [SAMPLE_WIDTH-1:0]     out_z_o
);

  import jdz_pkg::*;

  localparam int W      = SAMPLE_WIDTH;
  localparam int SW     = 2 * W;
  localparam int RT     = 2 * W + 1;
  localparam int XW     = ((W > THR_W) ? W : THR_W) + 1;
  localparam int SNUM_W = 30;
  localparam int LNUM_W = (W + QUO_W > SNUM_W) ? W + QUO_W : SNUM_W;
  localparam int LDEN_W = (W > THR_W) ? W : THR_W;
  localparam int RSW    = (W > 17) ? W : 17;
  localparam int ST_SUM = 2;
  localparam int ST_SQ0 = 3;
  localparam int ST_SP  = ST_SQ0 + W;
  localparam int ST_M   = ST_SP + QUO_W + 1;
  localparam int NSTAGE = ST_M + QUO_W + 1;

  typedef struct packed {
    logic [1:0]          kind;
    logic                radial;
    logic [2:0][W-1:0]   raw;
    logic [2:0][W-1:0]   mag;
    logic [2:0]          neg;
    logic                s_nz;
    logic [W-1:0]        len;
    logic                sc_zero;
    logic                sc_full;
    logic [2:0]          ln_zero;
    logic [2:0]          ln_full;
  } item_t;

  typedef struct packed {
    logic              zero;
    logic              full;
    logic [SNUM_W-1:0] num;
    logic [THR_W-1:0]  den;
  } rsc_t;

  // Prepare one rescale: zero and full-scale cases, else the division.
  function automatic rsc_t rsc_prep(input logic [W-1:0] m, input logic [THR_W-1:0] lo,
                                    input logic [THR_W-1:0] up);
    rsc_t             r;
    logic [XW-1:0]    me;
    logic [XW-1:0]    le;
    logic [XW-1:0]    x;
    logic [THR_W-1:0] span;
    me     = XW'(m);
    le     = XW'(lo);
    x      = me - le;
    span   = up - lo;
    r.zero = (me <= le);
    r.full = !r.zero && ((up <= lo) || (x >= XW'(span)));
    r.num  = SNUM_W'({x[THR_W-1:0], {FRAC_BITS{1'b0}}}) + SNUM_W'(span[THR_W-1:1]);
    r.den  = span;
    return r;
  endfunction

  // Apply sign and saturate to the sample range.
  function automatic logic [W-1:0] lane_out(input logic neg, input logic zero,
                                            input logic full, input logic [QUO_W-1:0] q);
    logic [QUO_W-1:0] mg;
    logic [RSW-1:0]   sv;
    logic [RSW-1:0]   hi;
    logic [RSW-1:0]   lo;
    mg = zero ? '0 : (full ? ONE_Q : q);
    sv = neg ? (RSW'(0) - RSW'(mg)) : RSW'(mg);
    hi = RSW'({(W-1){1'b1}});
    lo = ~hi;
    if ($signed(sv) > $signed(hi)) begin
      sv = hi;
    end else if ($signed(sv) < $signed(lo)) begin
      sv = lo;
    end
    return sv[W-1:0];
  endfunction

  // Configuration registers.
  logic [THR_W-1:0] move_thr_q, look_thr_q, upper_thr_q;
  logic             stick_sel_q, dz_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_thr_q  <= RST_MOVE_THR;
      look_thr_q  <= RST_LOOK_THR;
      stick_sel_q <= RST_STICK_SEL;
      upper_thr_q <= RST_UPPER_THR;
      dz_mode_q   <= RST_DZ_MODE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MOVE_THR:  move_thr_q  <= cfg_data_i;
        REG_LOOK_THR:  look_thr_q  <= cfg_data_i;
        REG_STICK_SEL: stick_sel_q <= cfg_data_i[0];
        REG_UPPER_THR: upper_thr_q <= cfg_data_i;
        REG_DZ_MODE:   dz_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Selected lower threshold, clamped to one.
  logic [THR_W-1:0] sel_thr, lower;
  assign sel_thr = stick_sel_q ? look_thr_q : move_thr_q;
  assign lower   = (sel_thr > ONE_Q) ? ONE_Q : sel_thr;

  // Pipeline control: every stage moves together unless the output is blocked.
  logic              adv;
  logic [NSTAGE-1:0] valid_q;
  logic              out_valid_q;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q     <= {valid_q[NSTAGE-2:0], in_valid_i};
      out_valid_q <= valid_q[NSTAGE-1];
    end
  end

  // Input capture: mask unused axes and split into sign and magnitude.
  item_t            in_item;
  logic [2:0][W-1:0] in_raw;
  logic [2:0]       in_use;

  assign in_raw = {in_z_i, in_y_i, in_x_i};
  assign in_use = {kind_i == KIND_3D, kind_i == KIND_2D || kind_i == KIND_3D,
                   kind_i != KIND_BOOL};

  always_comb begin
    in_item        = '0;
    in_item.kind   = kind_i;
    in_item.radial = (dz_mode_q == MODE_RADIAL) && (kind_i == KIND_2D || kind_i == KIND_3D);
    in_item.raw    = in_raw;
    for (int i = 0; i < 3; i++) begin
      in_item.neg[i] = in_use[i] && in_raw[i][W-1];
      if (!in_use[i]) begin
        in_item.mag[i] = '0;
      end else if (in_raw[i][W-1]) begin
        in_item.mag[i] = ~in_raw[i] + W'(1);
      end else begin
        in_item.mag[i] = in_raw[i];
      end
    end
  end

  // Per-stage item record.
  item_t item_q [NSTAGE];
  item_t item_d [NSTAGE];

  // Squares and their sum.
  logic [SW-1:0] sq_q [3];
  logic [SW-1:0] sum_q;
  logic [SW-1:0] sum_d;

  assign sum_d = sq_q[0] + sq_q[1] + sq_q[2];

  // Square root, one result bit per stage.
  logic [RT-1:0] sqr_rem_q [W];
  logic [RT-1:0] sqr_res_q [W];

  for (genvar j = 0; j < W; j++) begin : g_sqrt
    logic [RT-1:0] rem_in;
    logic [RT-1:0] res_in;
    logic [RT-1:0] trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = RT'(sum_q);
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = sqr_rem_q[j-1];
      assign res_in = sqr_res_q[j-1];
    end

    assign trial = res_in + (RT'(1) << (2 * (W - 1 - j)));
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sqr_rem_q[j] <= ge ? (rem_in - trial) : rem_in;
        sqr_res_q[j] <= ge ? ((res_in >> 1) + (RT'(1) << (2 * (W - 1 - j))))
                           : (res_in >> 1);
      end
    end
  end

  logic [W-1:0] sqrt_len;
  assign sqrt_len = sqr_res_q[W-1][W-1:0];

  // Rescale of the vector length.
  rsc_t              sc_prep;
  logic [SNUM_W-1:0] sc_num_q;
  logic [THR_W-1:0]  sc_den_q;
  logic [QUO_W-1:0]  sc_quo;

  assign sc_prep = rsc_prep(sqrt_len, lower, upper_thr_q);

  jdz_div #(
    .NUM_W (SNUM_W),
    .DEN_W (THR_W),
    .QUO_W (QUO_W)
  ) u_scale_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (sc_num_q),
    .den_i (sc_den_q),
    .quo_o (sc_quo)
  );

  // Lane preparation: radial component scaling or axial rescale.
  item_t             m_item;
  logic [QUO_W-1:0]  scale;
  logic [LNUM_W-1:0] ln_num_d [3];
  logic [LDEN_W-1:0] ln_den_d [3];
  logic [2:0]        ln_zero_d, ln_full_d;
  logic [LNUM_W-1:0] ln_num_q [3];
  logic [LDEN_W-1:0] ln_den_q [3];
  logic [QUO_W-1:0]  ln_quo [3];

  assign m_item = item_q[ST_M-1];
  assign scale  = m_item.sc_zero ? '0 : (m_item.sc_full ? ONE_Q : sc_quo);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsc_t ax;
      ax = rsc_prep(m_item.mag[i], lower, upper_thr_q);
      if (m_item.radial) begin
        ln_zero_d[i] = (m_item.mag[i] == '0);
        ln_full_d[i] = 1'b0;
        ln_num_d[i]  = LNUM_W'(m_item.mag[i]) * LNUM_W'(scale)
                     + LNUM_W'(m_item.len >> 1);
        ln_den_d[i]  = LDEN_W'(m_item.len);
      end else begin
        ln_zero_d[i] = ax.zero;
        ln_full_d[i] = ax.full;
        ln_num_d[i]  = LNUM_W'(ax.num);
        ln_den_d[i]  = LDEN_W'(ax.den);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    jdz_div #(
      .NUM_W (LNUM_W),
      .DEN_W (LDEN_W),
      .QUO_W (QUO_W)
    ) u_lane_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (ln_num_q[i]),
      .den_i (ln_den_q[i]),
      .quo_o (ln_quo[i])
    );
  end

  // Next item records, with stage-specific fields filled in.
  always_comb begin
    item_d[0] = in_item;
    for (int i = 1; i < NSTAGE; i++) begin
      item_d[i] = item_q[i-1];
    end
    item_d[ST_SUM].s_nz   = |sum_d;
    item_d[ST_SP].len     = sqrt_len;
    item_d[ST_SP].sc_zero = sc_prep.zero;
    item_d[ST_SP].sc_full = sc_prep.full;
    item_d[ST_M].ln_zero  = ln_zero_d;
    item_d[ST_M].ln_full  = ln_full_d;
  end

  // Output word.
  item_t        o_item;
  logic [W-1:0] out_d [3];
  logic [W-1:0] out_q [3];

  assign o_item = item_q[NSTAGE-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (o_item.kind == KIND_BOOL) begin
        out_d[i] = o_item.raw[i];
      end else begin
        out_d[i] = lane_out(o_item.neg[i], o_item.ln_zero[i], o_item.ln_full[i], ln_quo[i]);
      end
    end
  end

  // Payload registers of all stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      item_q <= item_d;
      for (int i = 0; i < 3; i++) begin
        sq_q[i]     <= SW'(item_q[0].mag[i]) * SW'(item_q[0].mag[i]);
        ln_num_q[i] <= ln_num_d[i];
        ln_den_q[i] <= ln_den_d[i];
        out_q[i]    <= out_d[i];
      end
      sum_q    <= sum_d;
      sc_num_q <= sc_prep.num;
      sc_den_q <= sc_prep.den;
    end
  end

  assign out_x_o = out_q[0];
  assign out_y_o = out_q[1];
  assign out_z_o = out_q[2];

endmodule

[design/jdz_div.sv]
// ----------------------------------------------------------------------------
// jdz_div: pipelined restoring divider
// One quotient bit per register stage, most significant first. The caller
// guarantees that the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module jdz_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 15,
  parameter int QUO_W = 15
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [CW-1:0]    rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [CW-1:0]    rem_in;
    logic [CW-1:0]    dsh;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_in = CW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    // Trial subtraction of the shifted divisor for this quotient bit.
    assign dsh  = CW'(den_in) << (QUO_W - 1 - j);
    assign take = (rem_in >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? (rem_in - dsh) : rem_in;
        den_q[j] <= den_in;
        quo_q[j] <= quo_in | (take ? (QUO_W'(1) << (QUO_W - 1 - j)) : '0);
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for the stick dead-zone rescaler
// Drives stick words through the valid/ready input channel, predicts each
// rescaled word from the register settings, and compares every output word
// in order. Registers are rewritten between phases while the pipeline is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jdz_pkg::*;

  localparam int SW        = DEFAULT_SAMPLE_WIDTH;
  localparam int LATENCY   = SW + 36;
  localparam int MAX_CYCLE = 1500000;

  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] z;
  } stick_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] kind_i = '0;
  logic signed [SW-1:0] in_x_i = '0, in_y_i = '0, in_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SW-1:0] out_x_o, out_y_o, out_z_o;

  // Shadow copy of the registers.
  logic [14:0] move_thr, look_thr, upper_thr;
  logic        stick_sel, dz_mode;

  stick_t expected_words[$];
  int     mismatches = 0;
  int     cycle = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  joystick_dead_zone_rescale #(.SAMPLE_WIDTH(SW)) i_dut (.*);

  always #5ns clk_i = ~clk_i;

  // Watchdog on the run length.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver ready, stalling at random.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Magnitude rescale through the dead zone, result in Q2.14.
  function automatic longint dz_rescale(longint m, longint lower, longint upper);
    longint span, q;
    if (m <= lower) return 0;
    if (upper <= lower) return 16384;
    span = upper - lower;
    q = ((m - lower) * 16384 + span / 2) / span;
    return (q > 16384) ? 16384 : q;
  endfunction

  function automatic longint int_sqrt(longint s);
    longint lo, hi, mid;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= s) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic signed [SW-1:0] sat(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[SW-1:0];
  endfunction

  // Predicted output word for one stick word.
  function automatic stick_t predict_stick(kind_e kind, stick_t s);
    longint v[3], r[3], a[3], lower, len, scale, sq;
    stick_t res;
    v[0] = s.x; v[1] = s.y; v[2] = s.z;
    r = '{0, 0, 0};
    if (kind == KIND_BOOL) return s;
    if (kind != KIND_3D) v[2] = 0;
    if (kind == KIND_1D) v[1] = 0;
    lower = stick_sel ? look_thr : move_thr;
    if (lower > 16384) lower = 16384;
    for (int i = 0; i < 3; i++) a[i] = (v[i] < 0) ? -v[i] : v[i];
    if (dz_mode == MODE_AXIAL || kind == KIND_1D) begin
      for (int i = 0; i < 3; i++) begin
        r[i] = dz_rescale(a[i], lower, upper_thr);
        if (v[i] < 0) r[i] = -r[i];
      end
    end else begin
      sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      if (sq != 0) begin
        len = int_sqrt(sq);
        scale = dz_rescale(len, lower, upper_thr);
        for (int i = 0; i < 3; i++) begin
          r[i] = (a[i] * scale + len / 2) / len;
          if (v[i] < 0) r[i] = -r[i];
        end
      end
    end
    res.x = sat(r[0]);
    res.y = sat(r[1]);
    res.z = sat(r[2]);
    return res;
  endfunction

  // Output checker: each word against the oldest prediction.
  always @(posedge clk_i) begin
    stick_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %0d %0d %0d",
                                       out_x_o, out_y_o, out_z_o);
      end else begin
        exp_w = expected_words.pop_front();
        if (out_x_o !== exp_w.x || out_y_o !== exp_w.y || out_z_o !== exp_w.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     exp_w.x, exp_w.y, exp_w.z, out_x_o, out_y_o, out_z_o);
        end
      end
    end
  end

  // Sends one stick word and records its prediction on acceptance. Valid stays
  // high after acceptance so that the next word can follow directly; idle
  // cycles and drain() drop it.
  task automatic send_stick(kind_e kind, stick_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    in_x_i     <= s.x;
    in_y_i     <= s.y;
    in_z_i     <= s.z;
    do @(posedge clk_i); while (!in_ready_o);
    expected_words.push_back(predict_stick(kind, s));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  // Register write; only called with the pipeline empty. The caller drops
  // valid after its last write.
  task automatic write_reg(cfg_idx_e idx, logic [14:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MOVE_THR:  move_thr  = data;
      REG_LOOK_THR:  look_thr  = data;
      REG_STICK_SEL: stick_sel = data[0];
      REG_UPPER_THR: upper_thr = data;
      REG_DZ_MODE:   dz_mode   = data[0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [14:0] mv, logic [14:0] lk, logic sel,
                         logic [14:0] up, logic mode);
    write_reg(REG_MOVE_THR, mv);
    write_reg(REG_LOOK_THR, lk);
    write_reg(REG_STICK_SEL, 15'(sel));
    write_reg(REG_UPPER_THR, up);
    write_reg(REG_DZ_MODE, 15'(mode));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [SW-1:0] rand_axis();
    case ($urandom_range(5))
      0: return SW'($urandom);
      1: return $urandom_range(1) ? -16'sd32768 : 16'sd32767;
      2: return SW'(int'($urandom_range(64)) - 32);
      default: return SW'(int'($urandom_range(40000)) - 20000);
    endcase
  endfunction

  // Directed words: field extremes, every kind, threshold edges.
  task automatic test_directed();
    stick_t s;
    kind_e  k;
    for (int i = 0; i < 4; i++) begin
      k = kind_e'(i);
      send_stick(k, '{16'sd32767, -16'sd32768, 16'sd1});
      send_stick(k, '{-16'sd32768, 16'sd32767, -16'sd1});
      send_stick(k, '{16'sd0, 16'sd0, 16'sd0});
    end
    // Magnitudes right at and just above the lower threshold.
    s = '{16'sd3277, -16'sd3277, 16'sd3278};
    send_stick(KIND_3D, s);
    s = '{16'sd3278, 16'sd0, -16'sd16384};
    send_stick(KIND_2D, s);
    send_stick(KIND_1D, '{-16'sd3278, 16'sd5, 16'sd5});
  endtask

  task automatic test_random(int n);
    stick_t s;
    for (int i = 0; i < n; i++) begin
      s.x = rand_axis();
      s.y = rand_axis();
      s.z = rand_axis();
      send_stick(kind_e'($urandom_range(3)), s);
    end
  endtask

  // One setting and one idling phase per pass.
  task automatic test_settings();
    logic [14:0] cfg_vals[5];
    int pcts[4][2] = '{'{0, 0}, '{81, 0}, '{0, 81}, '{18, 18}};
    for (int p = 0; p < 16; p++) begin
      drain();
      case (p)
        0: set_all(15'd0, 15'd0, 1'b0, 15'd16384, MODE_AXIAL);
        1: set_all(15'd0, 15'd32767, 1'b1, 15'd32767, MODE_RADIAL);
        2: set_all(15'd32767, 15'd100, 1'b0, 15'd0, MODE_RADIAL);
        3: set_all(15'd8000, 15'd16384, 1'b1, 15'd8000, MODE_AXIAL);
        4: set_all(15'd16385, 15'd2000, 1'b0, 15'd16384, MODE_AXIAL);
        5: set_all(15'd3277, 15'd4000, 1'b1, 15'd12000, MODE_RADIAL);
        default: begin
          cfg_vals[0] = 15'($urandom_range(17000));
          cfg_vals[1] = 15'($urandom_range(17000));
          cfg_vals[3] = ($urandom_range(3) == 0) ? 15'($urandom) :
                        15'($urandom_range(16384));
          set_all(cfg_vals[0], cfg_vals[1], 1'($urandom), cfg_vals[3], 1'($urandom));
        end
      endcase
      send_idle_pct  = pcts[p % 4][0];
      recv_stall_pct = pcts[p % 4][1];
      test_random(70);
    end
  endtask

  initial begin
    move_thr  = RST_MOVE_THR;
    look_thr  = RST_LOOK_THR;
    stick_sel = RST_STICK_SEL;
    upper_thr = RST_UPPER_THR;
    dz_mode   = RST_DZ_MODE;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Reset defaults first, then radial directed words.
    test_directed();
    drain();
    write_reg(REG_DZ_MODE, 15'(MODE_RADIAL));
    cfg_valid_i <= 1'b0;
    test_directed();
    test_settings();
    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
design/jdz_pkg.sv
design/jdz_div.sv
design/joystick_dead_zone_rescale.sv
sim/tb.sv
